/* design/sequence_reorder_buffer_macros.svh */
// Assertion helpers used by the checker file.
`ifndef SEQUENCE_REORDER_BUFFER_MACROS_SVH
`define SEQUENCE_REORDER_BUFFER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SRB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SRB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/srb_pkg.sv */
`timescale 1ns / 1ps

package srb_pkg;

    localparam int WINDOW_DEF = 16;
    localparam int SEQ_W      = 32;
    localparam int TAG_W      = 32;
    // s_tdata: seq_num, payload_tag, reply_wanted, padded to whole bytes
    localparam int S_TDATA_W  = 72;
    // m_tdata: out_seq, out_payload, ack_next, ack_highest
    localparam int M_TDATA_W  = 128;

    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_JOIN = 1'b1;
    localparam logic KIND_PKT = 1'b0;
    localparam logic KIND_ACK = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CLEAR = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_ACK   = 4'b1000
    } state_t;

    typedef enum logic [1:0] {
        OUT_PKT_IN   = 2'd0,
        OUT_PKT_SLOT = 2'd1,
        OUT_ACK      = 2'd2
    } out_sel_t;

    typedef struct packed {
        logic     out_load;
        out_sel_t out_sel;
        logic     out_last;
        logic     advance;
        logic     clear_cur;
        logic     cnt_dec;
        logic     write_slot;
        logic     raise_high;
        logic     join_far;
        logic     load_cnt;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_join;
        logic seq_lt;
        logic seq_eq;
        logic in_win;
        logic slot_free;
        logic cur_valid;
        logic nxt_valid;
        logic cnt_last;
        logic reply;
        logic out_free;
    } dp_stat_t;

endpackage

/* design/srb_ctrl.sv */
`timescale 1ns / 1ps

module srb_ctrl
    import srb_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  dp_stat_t  stat,
    output ctrl_cmd_t cmd
);

    state_t state_reg, state_next;
    logic   ack_pending_reg, ack_pending_next;
    logic   fire;

    assign s_tready = (state_reg == ST_IDLE) && stat.out_free;
    assign fire     = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            ack_pending_reg <= 1'b0;
        end else begin
            state_reg       <= state_next;
            ack_pending_reg <= ack_pending_next;
        end
    end

    always_comb begin
        cmd              = '0;
        cmd.out_sel      = OUT_PKT_IN;
        state_next       = state_reg;
        ack_pending_next = ack_pending_reg;
        case (state_reg)
            ST_IDLE: begin
                if (fire) begin
                    if (stat.is_join) begin
                        if (!stat.seq_lt && !stat.seq_eq) begin
                            cmd.raise_high   = 1'b1;
                            ack_pending_next = 1'b0;
                            if (stat.in_win) begin
                                cmd.load_cnt = 1'b1;
                                state_next   = ST_CLEAR;
                            end else begin
                                // every stored item falls below the target
                                cmd.join_far = 1'b1;
                            end
                        end
                    end else if (stat.seq_lt) begin
                        if (stat.reply) begin
                            cmd.out_load = 1'b1;
                            cmd.out_sel  = OUT_ACK;
                            cmd.out_last = 1'b1;
                        end
                    end else if (stat.seq_eq) begin
                        cmd.out_load     = 1'b1;
                        cmd.out_sel      = OUT_PKT_IN;
                        cmd.out_last     = !stat.nxt_valid && !stat.reply;
                        cmd.advance      = 1'b1;
                        ack_pending_next = stat.reply;
                        if (stat.nxt_valid) begin
                            state_next = ST_DRAIN;
                        end else if (stat.reply) begin
                            state_next = ST_ACK;
                        end
                    end else if (stat.in_win) begin
                        cmd.raise_high = 1'b1;
                        cmd.write_slot = stat.slot_free;
                    end
                end
            end
            ST_CLEAR: begin
                // drop one stored item below the join target per cycle
                cmd.clear_cur = 1'b1;
                cmd.advance   = 1'b1;
                cmd.cnt_dec   = 1'b1;
                if (stat.cnt_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!stat.cur_valid) begin
                    state_next = ack_pending_reg ? ST_ACK : ST_IDLE;
                end else if (stat.out_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.out_sel   = OUT_PKT_SLOT;
                    cmd.out_last  = !stat.nxt_valid && !ack_pending_reg;
                    cmd.clear_cur = 1'b1;
                    cmd.advance   = 1'b1;
                    if (!stat.nxt_valid) begin
                        state_next = ack_pending_reg ? ST_ACK : ST_IDLE;
                    end
                end
            end
            ST_ACK: begin
                if (stat.out_free) begin
                    cmd.out_load     = 1'b1;
                    cmd.out_sel      = OUT_ACK;
                    cmd.out_last     = 1'b1;
                    ack_pending_next = 1'b0;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* design/srb_dp.sv */
`timescale 1ns / 1ps

module srb_dp
    import srb_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tuser,
    output logic                 m_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  ctrl_cmd_t            cmd,
    output dp_stat_t             stat
);

    localparam int IDX_W = $clog2(WINDOW);

    logic [SEQ_W-1:0]  exp_seq_reg, exp_seq_next;
    logic [SEQ_W-1:0]  high_seq_reg, high_seq_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic [WINDOW-1:0] valid_reg, valid_next;
    logic [TAG_W-1:0]  rd_data_reg;
    logic [TAG_W-1:0]  mem [WINDOW];

    logic              m_valid_reg, m_valid_next;
    logic              m_kind_reg;
    logic              m_last_reg;
    logic [SEQ_W-1:0]  m_seq_reg;
    logic [TAG_W-1:0]  m_pay_reg;
    logic [SEQ_W-1:0]  m_anext_reg;
    logic [SEQ_W-1:0]  m_ahigh_reg;

    logic [SEQ_W-1:0]  in_seq;
    logic [TAG_W-1:0]  in_pay;
    logic              in_reply;
    logic [SEQ_W-1:0]  seq_gap;
    logic [IDX_W:0]    slot_sum;
    logic [IDX_W-1:0]  slot;
    logic [IDX_W-1:0]  idx_inc;

    assign in_seq   = s_tdata[SEQ_W-1:0];
    assign in_pay   = s_tdata[SEQ_W+TAG_W-1:SEQ_W];
    assign in_reply = s_tdata[SEQ_W+TAG_W];

    // slots are addressed relative to the expected item's slot
    assign seq_gap  = in_seq - exp_seq_reg;
    assign slot_sum = {1'b0, idx_reg} + {1'b0, seq_gap[IDX_W-1:0]};
    assign slot     = (slot_sum >= (IDX_W+1)'(WINDOW))
                    ? IDX_W'(slot_sum - (IDX_W+1)'(WINDOW)) : slot_sum[IDX_W-1:0];
    assign idx_inc  = (idx_reg == IDX_W'(WINDOW - 1)) ? '0 : idx_reg + 1'b1;

    always_comb begin
        stat.is_join   = (s_tuser == CMD_JOIN);
        stat.seq_lt    = in_seq < exp_seq_reg;
        stat.seq_eq    = in_seq == exp_seq_reg;
        stat.in_win    = seq_gap < SEQ_W'(WINDOW);
        stat.slot_free = !valid_reg[slot];
        stat.cur_valid = valid_reg[idx_reg];
        stat.nxt_valid = valid_reg[idx_inc];
        stat.cnt_last  = cnt_reg == IDX_W'(1);
        stat.reply     = in_reply;
        stat.out_free  = !m_valid_reg || m_tready;
    end

    always_comb begin
        exp_seq_next  = exp_seq_reg;
        idx_next      = idx_reg;
        high_seq_next = high_seq_reg;
        cnt_next      = cnt_reg;
        valid_next    = valid_reg;
        if (cmd.join_far) begin
            exp_seq_next = in_seq;
            valid_next   = '0;
        end
        if (cmd.advance) begin
            exp_seq_next = exp_seq_reg + 1'b1;
            idx_next     = idx_inc;
        end
        if (cmd.clear_cur) begin
            valid_next[idx_reg] = 1'b0;
        end
        if (cmd.write_slot) begin
            valid_next[slot] = 1'b1;
        end
        if (cmd.raise_high && (in_seq > high_seq_reg)) begin
            high_seq_next = in_seq;
        end
        if (cmd.load_cnt) begin
            cnt_next = seq_gap[IDX_W-1:0];
        end else if (cmd.cnt_dec) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_seq_reg  <= '0;
            high_seq_reg <= '0;
            idx_reg      <= '0;
            cnt_reg      <= '0;
            valid_reg    <= '0;
        end else begin
            exp_seq_reg  <= exp_seq_next;
            high_seq_reg <= high_seq_next;
            idx_reg      <= idx_next;
            cnt_reg      <= cnt_next;
            valid_reg    <= valid_next;
        end
    end

    // payload store; prefetch the slot that will be expected next cycle
    always_ff @(posedge aclk) begin
        if (cmd.write_slot) begin
            mem[slot] <= in_pay;
        end
        rd_data_reg <= mem[idx_next];
    end

    assign m_valid_next = cmd.out_load ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_last_reg <= cmd.out_last;
            case (cmd.out_sel)
                OUT_PKT_IN: begin
                    m_kind_reg  <= KIND_PKT;
                    m_seq_reg   <= in_seq;
                    m_pay_reg   <= in_pay;
                    m_anext_reg <= '0;
                    m_ahigh_reg <= '0;
                end
                OUT_PKT_SLOT: begin
                    m_kind_reg  <= KIND_PKT;
                    m_seq_reg   <= exp_seq_reg;
                    m_pay_reg   <= rd_data_reg;
                    m_anext_reg <= '0;
                    m_ahigh_reg <= '0;
                end
                OUT_ACK: begin
                    m_kind_reg  <= KIND_ACK;
                    m_seq_reg   <= '0;
                    m_pay_reg   <= '0;
                    m_anext_reg <= exp_seq_reg;
                    m_ahigh_reg <= high_seq_reg;
                end
                default: begin
                    m_kind_reg  <= KIND_ACK;
                    m_seq_reg   <= '0;
                    m_pay_reg   <= '0;
                    m_anext_reg <= '0;
                    m_ahigh_reg <= '0;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {m_ahigh_reg, m_anext_reg, m_pay_reg, m_seq_reg};

endmodule

/* design/sequence_reorder_buffer.sv */
`timescale 1ns / 1ps

// Channel   Direction  tdata (low bit up)                              tuser  tlast
// s_        in         seq_num, payload_tag, reply_wanted, zero pad    command  -
// m_        out        out_seq, out_payload, ack_next, ack_highest     kind   last
//
// An old, stored, dropped or stale item, or a join beyond the window, is taken without leaving the idle state.
// An in-order packet is passed on, then the stored items that follow it drain, then the ack if wanted;
// the output register accepts one result per cycle while m_ does not stall.
// A join within the window clears each skipped slot in turn, then drains the stored items
// from the target on, if any.
// Synchronous active-low reset clears the slot valid flags and both sequence counters.
// s_tready stays low while the current item is still in work (skipped slots or results pending) or m_ stalls.

module sequence_reorder_buffer
    import srb_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // seq_num, payload_tag, reply_wanted
    input  logic                 s_tuser,   // command
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // out_seq, out_payload, ack_next, ack_highest
    output logic                 m_tuser,   // kind
    output logic                 m_tlast
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    srb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    srb_dp #(
        .WINDOW (WINDOW)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

/* design/srb_checker.sv */
`timescale 1ns / 1ps
`include "sequence_reorder_buffer_macros.svh"

module srb_checker
    import srb_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser,
    input logic                 m_tlast
);

    `SRB_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result item changed while stalled")
    `SRB_ASSERT_NOW(a_ack_last, aclk, aresetn, m_tvalid && (m_tuser == KIND_ACK), m_tlast, "ack item without last")
    `SRB_ASSERT_NOW(a_ack_clean, aclk, aresetn, m_tvalid && (m_tuser == KIND_ACK), m_tdata[2*SEQ_W-1:0] == '0, "ack item carries packet fields")
    `SRB_ASSERT_NOW(a_no_take_stall, aclk, aresetn, m_tvalid && !m_tready, !s_tready, "input taken while result stalled")

endmodule

bind sequence_reorder_buffer srb_checker u_srb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import srb_pkg::*;

    localparam int unsigned WIN   = WINDOW_DEF;
    localparam int unsigned LIMIT = 300000;

    typedef struct packed {
        logic        cmd;
        logic [31:0] seq;
        logic [31:0] tag;
        logic        reply;
    } item_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] seq;
        logic [31:0] tag;
        logic [31:0] ack_next;
        logic [31:0] ack_high;
        logic        last;
    } result_t;

    // How a directed row is checked: by the predictor, or against a typed-in outcome
    typedef enum logic [1:0] {
        BY_MODEL,
        NO_RESULT,
        ONE_RESULT
    } row_chk_t;

    typedef struct packed {
        logic        cmd;
        logic [31:0] seq;
        logic [31:0] tag;
        logic        reply;
        row_chk_t    check;
        logic        r_kind;
        logic [31:0] r_seq;
        logic [31:0] r_tag;
        logic [31:0] r_next;
        logic [31:0] r_high;
    } row_t;

    localparam row_t DIRECTED [25] = '{
        '{CMD_DATA, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, ONE_RESULT,
          KIND_PKT, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0},
        // old packet, ack reports the state
        '{CMD_DATA, 32'h0000_0000, 32'h1234_5678, 1'b1, ONE_RESULT,
          KIND_ACK, 32'h0, 32'h0, 32'h1, 32'h0},
        '{CMD_DATA, 32'h0000_0000, 32'h0, 1'b0, NO_RESULT,
          KIND_PKT, 32'h0, 32'h0, 32'h0, 32'h0},
        // one past the window edge
        '{CMD_DATA, 32'h0000_0011, 32'hAAAA_AAAA, 1'b1, NO_RESULT,
          KIND_PKT, 32'h0, 32'h0, 32'h0, 32'h0},
        '{CMD_DATA, 32'h0000_0010, 32'hA5A5_A5A5, 1'b1, NO_RESULT,
          KIND_PKT, 32'h0, 32'h0, 32'h0, 32'h0},
        // duplicate keeps the first payload
        '{CMD_DATA, 32'h0000_0010, 32'h5A5A_5A5A, 1'b1, NO_RESULT,
          KIND_PKT, 32'h0, 32'h0, 32'h0, 32'h0},
        '{CMD_DATA, 32'h0000_0003, 32'h0000_0033, 1'b0, NO_RESULT,
          KIND_PKT, 32'h0, 32'h0, 32'h0, 32'h0},
        '{CMD_DATA, 32'h0000_0002, 32'h0000_0022, 1'b1, NO_RESULT,
          KIND_PKT, 32'h0, 32'h0, 32'h0, 32'h0},
        '{CMD_DATA, 32'h0000_0001, 32'h0, 1'b1, BY_MODEL,
          KIND_PKT, 32'h0, 32'h0, 32'h0, 32'h0},
        '{CMD_DATA, 32'h0000_0002, 32'h0, 1'b1, ONE_RESULT,
          KIND_ACK, 32'h0, 32'h0, 32'h4, 32'h10},
        // stale joins, at and below the expected number
        '{CMD_JOIN, 32'h0000_0004, 32'h0, 1'b1, NO_RESULT,
          KIND_PKT, 32'h0, 32'h0, 32'h0, 32'h0},
        '{CMD_JOIN, 32'h0000_0002, 32'h0, 1'b1, NO_RESULT,
          KIND_PKT, 32'h0, 32'h0, 32'h0, 32'h0},
        '{CMD_DATA, 32'h0000_0005, 32'h0000_0055, 1'b0, NO_RESULT,
          KIND_PKT, 32'h0, 32'h0, 32'h0, 32'h0},
        '{CMD_DATA, 32'h0000_0006, 32'h0000_0066, 1'b1, NO_RESULT,
          KIND_PKT, 32'h0, 32'h0, 32'h0, 32'h0},
        '{CMD_JOIN, 32'h0000_0005, 32'hFFFF_FFFF, 1'b1, BY_MODEL,
          KIND_PKT, 32'h0, 32'h0, 32'h0, 32'h0},
        '{CMD_DATA, 32'h0000_000A, 32'h0000_1010, 1'b1, NO_RESULT,
          KIND_PKT, 32'h0, 32'h0, 32'h0, 32'h0},
        // far join clears the whole ring
        '{CMD_JOIN, 32'h8000_0000, 32'h0, 1'b0, NO_RESULT,
          KIND_PKT, 32'h0, 32'h0, 32'h0, 32'h0},
        '{CMD_DATA, 32'h7FFF_FFFF, 32'h0, 1'b1, ONE_RESULT,
          KIND_ACK, 32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000},
        '{CMD_DATA, 32'hFFFF_FFFF, 32'h0, 1'b1, NO_RESULT,
          KIND_PKT, 32'h0, 32'h0, 32'h0, 32'h0},
        '{CMD_JOIN, 32'hFFFF_FFFE, 32'h0, 1'b0, NO_RESULT,
          KIND_PKT, 32'h0, 32'h0, 32'h0, 32'h0},
        '{CMD_DATA, 32'hFFFF_FFFF, 32'hF0F0_F0F0, 1'b1, NO_RESULT,
          KIND_PKT, 32'h0, 32'h0, 32'h0, 32'h0},
        // expected number wraps to zero while draining
        '{CMD_DATA, 32'hFFFF_FFFE, 32'h0F0F_0F0F, 1'b1, BY_MODEL,
          KIND_PKT, 32'h0, 32'h0, 32'h0, 32'h0},
        '{CMD_DATA, 32'h0000_0000, 32'h0, 1'b0, ONE_RESULT,
          KIND_PKT, 32'h0, 32'h0, 32'h0, 32'h0},
        '{CMD_DATA, 32'h0000_0003, 32'h0000_0003, 1'b1, NO_RESULT,
          KIND_PKT, 32'h0, 32'h0, 32'h0, 32'h0},
        // join inside the window discards the stored packet it skips
        '{CMD_JOIN, 32'h0000_0005, 32'h0, 1'b1, NO_RESULT,
          KIND_PKT, 32'h0, 32'h0, 32'h0, 32'h0}
    };

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    // Predictor state
    logic [31:0]    next_seq;
    logic [31:0]    top_seq;
    logic [WIN-1:0] held;
    logic [31:0]    held_tag [WIN];

    result_t     fresh [$];
    result_t     due [$];
    int unsigned applied  = 0;
    int unsigned fail_cnt = 0;
    int unsigned cycles   = 0;
    int unsigned hold_left = 0;
    logic        hold_req  = 1'b0;
    logic        hold_done = 1'b0;
    logic        no_idle   = 1'b0;

    sequence_reorder_buffer u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Release consecutive stored packets from the expected number on
    task automatic drain_held();
        int unsigned k;
        int unsigned slot;
        for (k = 0; k < WIN; k++) begin
            slot = next_seq % WIN;
            if (!held[slot]) break;
            fresh.push_back('{KIND_PKT, next_seq, held_tag[slot], 32'h0, 32'h0, 1'b0});
            held[slot] = 1'b0;
            next_seq = next_seq + 32'd1;
        end
    endtask

    // Work out the results of one item; effect is low when the item is ignored
    task automatic resequence(input item_t it, output bit effect);
        logic [31:0] gap;
        logic [31:0] k;
        fresh.delete();
        effect = 1'b1;
        if (it.cmd == CMD_JOIN) begin
            if (it.seq <= next_seq) begin
                effect = 1'b0;
            end else begin
                gap = it.seq - next_seq;
                if (gap >= WIN) begin
                    held = '0;
                end else begin
                    for (k = 0; k < gap; k++) held[(next_seq + k) % WIN] = 1'b0;
                end
                next_seq = it.seq;
                if (top_seq < it.seq) top_seq = it.seq;
                drain_held();
            end
        end else if (it.seq < next_seq) begin
            effect = it.reply;
            if (it.reply) fresh.push_back('{KIND_ACK, 32'h0, 32'h0, next_seq, top_seq, 1'b0});
        end else if (it.seq == next_seq) begin
            fresh.push_back('{KIND_PKT, it.seq, it.tag, 32'h0, 32'h0, 1'b0});
            next_seq = next_seq + 32'd1;
            drain_held();
            if (it.reply) fresh.push_back('{KIND_ACK, 32'h0, 32'h0, next_seq, top_seq, 1'b0});
        end else if (it.seq - next_seq >= WIN) begin
            effect = 1'b0;
        end else begin
            if (top_seq < it.seq) top_seq = it.seq;
            if (!held[it.seq % WIN]) begin
                held[it.seq % WIN] = 1'b1;
                held_tag[it.seq % WIN] = it.tag;
            end
        end
        if (fresh.size() != 0) fresh[fresh.size() - 1].last = 1'b1;
    endtask

    // Present one item, hold it until taken, then predict
    task automatic offer(input item_t it, output bit effect);
        while (!no_idle && $urandom_range(0, 99) < 27) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.cmd;
        s_tdata  <= {{(S_TDATA_W - 65){1'b0}}, it.reply, it.tag, it.seq};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        resequence(it, effect);
    endtask

    task automatic send(input item_t it);
        bit eff;
        offer(it, eff);
        foreach (fresh[k]) due.push_back(fresh[k]);
        if (eff) applied++;
        if (applied == 120) hold_req <= 1'b1;
        no_idle <= (applied >= 200 && applied < 270);
    endtask

    function automatic item_t pkt(input logic [31:0] seq);
        pkt = '{CMD_DATA, seq, $urandom(), ($urandom_range(0, 99) < 75)};
    endfunction

    function automatic item_t join_to(input logic [31:0] seq);
        join_to = '{CMD_JOIN, seq, $urandom(), $urandom_range(0, 1) == 1};
    endfunction

    task automatic run_random();
        int unsigned ord [WIN];
        int unsigned len;
        int unsigned pick;
        int unsigned tmp;
        int unsigned n;
        int unsigned i;
        int unsigned j;
        logic [31:0] base;
        while (applied < 360) begin
            pick = $urandom_range(0, 99);
            base = next_seq;
            if (pick < 55) begin
                // shuffled window of packets, now and then a repeat
                len = ($urandom_range(0, 3) == 0) ? WIN : $urandom_range(1, WIN);
                for (i = 0; i < len; i++) ord[i] = i;
                for (i = len - 1; i > 0; i--) begin
                    j = $urandom_range(0, i);
                    tmp = ord[i];
                    ord[i] = ord[j];
                    ord[j] = tmp;
                end
                if (len == WIN && $urandom_range(0, 1) == 1) begin
                    // hold the in-order packet back so the whole ring drains at once
                    for (i = 0; i < len; i++) begin
                        if (ord[i] == 0) begin
                            ord[i] = ord[len - 1];
                            ord[len - 1] = 0;
                        end
                    end
                end
                for (i = 0; i < len; i++) begin
                    send(pkt(base + ord[i]));
                    if ($urandom_range(0, 9) == 0) send(pkt(base + ord[$urandom_range(0, i)]));
                end
            end else if (pick < 70) begin
                n = $urandom_range(0, WIN - 1);
                for (i = 0; i < n; i++) send(pkt(base + $urandom_range(1, WIN - 1)));
                send(join_to(base + $urandom_range(1, WIN)));
            end else if (pick < 78) begin
                if ($urandom_range(0, 3) == 0) begin
                    send(join_to(base - $urandom_range(0, 5)));
                end else begin
                    send(join_to($urandom()));
                end
            end else if (pick < 90) begin
                case ($urandom_range(0, 2))
                    0: begin
                        send(pkt(base - $urandom_range(1, 40)));
                    end
                    1: begin
                        send(pkt(base + $urandom_range(WIN, 100)));
                    end
                    default: begin
                        send(pkt($urandom()));
                    end
                endcase
            end else begin
                send(pkt(base));
            end
        end
    endtask

    // Receiver: random stalls, one long hold-off, and a stretch with none
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            m_tready  <= 1'b0;
            hold_left <= 400;
            hold_done <= 1'b1;
        end else begin
            m_tready <= no_idle || ($urandom_range(0, 99) >= 27);
        end
    end

    always @(posedge aclk) begin
        result_t want;
        result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tuser, m_tdata[31:0], m_tdata[63:32], m_tdata[95:64],
                    m_tdata[127:96], m_tlast};
            if (due.size() == 0) begin
                if (fail_cnt < 10)
                    $display("%0t unexpected result: kind %0d seq %h tag %h next %h high %h last %0d",
                             $realtime, got.kind, got.seq, got.tag, got.ack_next, got.ack_high,
                             got.last);
                fail_cnt++;
            end else begin
                want = due.pop_front();
                if (got.kind !== want.kind || got.seq !== want.seq || got.tag !== want.tag ||
                    got.ack_next !== want.ack_next || got.ack_high !== want.ack_high ||
                    got.last !== want.last) begin
                    if (fail_cnt < 10) begin
                        $display("%0t mismatch: want kind %0d seq %h tag %h next %h high %h last %0d",
                                 $realtime, want.kind, want.seq, want.tag, want.ack_next,
                                 want.ack_high, want.last);
                        $display("%0t           got  kind %0d seq %h tag %h next %h high %h last %0d",
                                 $realtime, got.kind, got.seq, got.tag, got.ack_next,
                                 got.ack_high, got.last);
                    end
                    fail_cnt++;
                end
            end
        end
    end

    initial begin
        item_t it;
        bit    eff;
        next_seq = '0;
        top_seq  = '0;
        held     = '0;
        foreach (held_tag[k]) held_tag[k] = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (DIRECTED[r]) begin
            it = '{DIRECTED[r].cmd, DIRECTED[r].seq, DIRECTED[r].tag, DIRECTED[r].reply};
            offer(it, eff);
            if (DIRECTED[r].check == BY_MODEL) begin
                foreach (fresh[k]) due.push_back(fresh[k]);
            end else if (DIRECTED[r].check == ONE_RESULT) begin
                due.push_back('{DIRECTED[r].r_kind, DIRECTED[r].r_seq, DIRECTED[r].r_tag,
                                DIRECTED[r].r_next, DIRECTED[r].r_high, 1'b1});
            end
        end

        run_random();
        s_tvalid <= 1'b0;

        while (due.size() != 0) @(posedge aclk);
        // allow for a late stray result
        repeat (64) @(posedge aclk);
        fail_cnt += due.size();
        if (fail_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
